[rtl/mss_pkg.sv]
// Shared types and constants of the multi-signature byte scanner.
package mss_pkg;

  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 3;
  localparam int INDEX_W   = 6;
  localparam int BYTE_W    = 8;
  localparam int OUT_OFF_W = 16;

  // transaction kinds on the input channel
  localparam logic [MODE_W-1:0] MODE_SIG_BYTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIG_LEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN     = 2'd2;

  // results per scanned byte are capped
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic               shift;     // history moves one cell down the row
    logic               step;      // prefix-match bits advance with feed
    logic               restart;   // ignore prefix bits of the previous byte
    logic               flush;     // clear all prefix bits
    logic               sig_we;    // signature byte write
    logic [BYTE_W-1:0]  feed;      // byte compared against the signatures
    logic [SLOT_W-1:0]  wr_slot;
    logic [INDEX_W-1:0] wr_index;
    logic [BYTE_W-1:0]  wr_data;
  } cell_ctrl_t;

endpackage

[rtl/mss_if.sv]
// Valid/ready channel interfaces for scan input and match results.
interface mss_in_if;
  logic                         valid;
  logic                         ready;
  logic [mss_pkg::MODE_W-1:0]   mode;
  logic [mss_pkg::SLOT_W-1:0]   slot;
  logic [mss_pkg::INDEX_W-1:0]  byte_index;
  logic [mss_pkg::BYTE_W-1:0]   value;
  logic                         start_of_file;

  modport source (output valid, mode, slot, byte_index, value, start_of_file,
                  input ready);
  modport sink   (input valid, mode, slot, byte_index, value, start_of_file,
                  output ready);
endinterface

interface mss_out_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::SLOT_W-1:0]     match_slot;
  logic [mss_pkg::OUT_OFF_W-1:0]  start_offset;
  logic                           last;

  modport source (output valid, match_slot, start_offset, last, input ready);
  modport sink   (input valid, match_slot, start_offset, last, output ready);
endinterface

[rtl/mss_cell.sv]
// One column of the matcher: a history byte, signature bytes and prefix-match bits.
module mss_cell #(
  parameter int NUM_SLOTS   = 8,
  parameter int MAX_SIG_LEN = 64,
  parameter int IDX         = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mss_pkg::cell_ctrl_t          ctrl,
  input  logic [mss_pkg::BYTE_W-1:0]   hist_in,
  output logic [mss_pkg::BYTE_W-1:0]   hist_out,
  input  logic [NUM_SLOTS-1:0]         bits_in,
  output logic [NUM_SLOTS-1:0]         bits_out,
  input  logic [$clog2(MAX_SIG_LEN+1)-1:0] len_i [NUM_SLOTS],
  output logic [NUM_SLOTS-1:0]         hit
);

  localparam bit  FIRST = (IDX == 0);

  logic [mss_pkg::BYTE_W-1:0] hist_r;
  logic [mss_pkg::BYTE_W-1:0] sig_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       bits_r;
  logic [NUM_SLOTS-1:0]       bits_nxt;
  logic [NUM_SLOTS-1:0]       prev_eff;
  logic [NUM_SLOTS-1:0]       eq;

  assign hist_out = hist_r;
  assign bits_out = bits_r;

  always_comb begin
    if (FIRST) begin
      prev_eff = '1;
    end else if (ctrl.restart) begin
      prev_eff = '0;
    end else begin
      prev_eff = bits_in;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      eq[s]  = (sig_r[s] == ctrl.feed);
      hit[s] = bits_r[s] && (32'(len_i[s]) == IDX + 1);
    end
    bits_nxt = prev_eff & eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else if (ctrl.flush) begin
      bits_r <= '0;
    end else if (ctrl.step) begin
      bits_r <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hist_r <= hist_in;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (ctrl.sig_we && 32'(ctrl.wr_slot) == s && 32'(ctrl.wr_index) == IDX) begin
        sig_r[s] <= ctrl.wr_data;
      end
    end
  end

endmodule

[rtl/multi_signature_byte_scanner.sv]
// Top level of the multi-signature byte scanner: cell row, sequencer and result stage.
//
// Scans a byte stream for exact occurrences of up to NUM_SLOTS signatures of up
// to MAX_SIG_LEN bytes. A row of MAX_SIG_LEN cells holds the last scanned bytes
// and, per slot, a bit that says "the first k+1 signature bytes end here"; each
// scanned byte advances every bit. A scan transaction is accepted, its hits are
// collected from the row, and then its match results (at most 8) leave one after
// another through the single result register, which holds while the receiver
// stalls; no new input is taken before the last result is registered. The
// first scan after any signature load first replays the history window through
// the cell row against the new signatures, with in_ch.ready low while the
// waiting scan is seen and for the whole replay. Results for one byte come in
// ascending slot order; last marks the final one. The offset counter saturates
// at all ones, and a byte scanned at that offset reports nothing.
module multi_signature_byte_scanner #(
  parameter int NUM_SLOTS   = 8,
  parameter int MAX_SIG_LEN = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mss_in_if.sink    in_ch,
  mss_out_if.source out_ch
);

  localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);
  localparam int REP_W = $clog2(MAX_SIG_LEN);
  localparam int DIF_W = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam int SEL_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RES_CNT_W_L = mss_pkg::RES_CNT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REPLAY = 2'd1;
  localparam logic [1:0] S_HITS   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic                           dirty_r, dirty_nxt;       // signatures changed since replay
  logic [REP_W-1:0]               rep_r, rep_nxt;           // replay step
  logic [LEN_W-1:0]               fill_r, fill_nxt;         // bytes since file start, capped
  logic [OFFSET_BITS-1:0]         off_r, off_nxt;           // offset of next scanned byte
  logic [OFFSET_BITS-1:0]         pos_r, pos_nxt;           // offset of current byte
  logic                           en_r, en_nxt;             // current byte may report
  logic [NUM_SLOTS-1:0]           pend_r, pend_nxt;         // matches still to deliver
  logic [RES_CNT_W_L-1:0]         ecnt_r, ecnt_nxt;
  logic [LEN_W-1:0]               len_r [NUM_SLOTS];
  logic [LEN_W-1:0]               len_nxt [NUM_SLOTS];

  // result register
  logic                           ovld_r, ovld_nxt;
  logic [mss_pkg::SLOT_W-1:0]     oslot_r, oslot_nxt;
  logic [mss_pkg::OUT_OFF_W-1:0]  ooff_r, ooff_nxt;
  logic                           olast_r, olast_nxt;

  // cell row
  mss_pkg::cell_ctrl_t            ctrl;
  logic [mss_pkg::BYTE_W-1:0]     hist [MAX_SIG_LEN];
  logic [NUM_SLOTS-1:0]           bits [MAX_SIG_LEN];
  logic [NUM_SLOTS-1:0]           hit  [MAX_SIG_LEN];
  logic [NUM_SLOTS-1:0]           hit_any;
  logic [mss_pkg::BYTE_W-1:0]     head;

  logic                           in_acc;
  logic                           rep_valid;
  logic [OFFSET_BITS-1:0]         base;
  logic                           sat;

  // lowest pending match
  logic [SEL_W-1:0]               sel;
  logic [NUM_SLOTS-1:0]           sel_oh;
  logic [LEN_W-1:0]               sel_len;
  logic [DIF_W-1:0]               diff;
  logic                           is_last;

  assign in_ch.ready = (state_r == S_IDLE) &&
                       !(dirty_r && in_ch.mode == mss_pkg::MODE_SCAN);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = ovld_r;
  assign out_ch.match_slot   = oslot_r;
  assign out_ch.start_offset = ooff_r;
  assign out_ch.last         = olast_r;

  // replay feeds the oldest byte first; steps older than the file start flush
  assign rep_valid = (32'(rep_r) + 32'(fill_r)) >= MAX_SIG_LEN;
  assign head      = (state_r == S_REPLAY) ? hist[MAX_SIG_LEN-1] : in_ch.value;

  always_comb begin
    ctrl          = '0;
    ctrl.feed     = head;
    ctrl.wr_slot  = in_ch.slot;
    ctrl.wr_index = in_ch.byte_index;
    ctrl.wr_data  = in_ch.value;
    if (state_r == S_REPLAY) begin
      ctrl.shift   = 1'b1;
      ctrl.step    = rep_valid;
      ctrl.flush   = !rep_valid;
      ctrl.restart = (rep_r == '0);
    end else if (in_acc && in_ch.mode == mss_pkg::MODE_SCAN) begin
      ctrl.shift   = 1'b1;
      ctrl.step    = 1'b1;
      ctrl.restart = in_ch.start_of_file;
    end else if (in_acc && in_ch.mode == mss_pkg::MODE_SIG_BYTE) begin
      ctrl.sig_we  = 1'b1;
    end
  end

  for (genvar k = 0; k < MAX_SIG_LEN; k++) begin : g_cell
    logic [mss_pkg::BYTE_W-1:0] h_in;
    logic [NUM_SLOTS-1:0]       b_in;
    if (k == 0) begin : g_head
      assign h_in = head;
      assign b_in = '0;
    end else begin : g_link
      assign h_in = hist[k-1];
      assign b_in = bits[k-1];
    end
    mss_cell #(
      .NUM_SLOTS  (NUM_SLOTS),
      .MAX_SIG_LEN(MAX_SIG_LEN),
      .IDX        (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .hist_in (h_in),
      .hist_out(hist[k]),
      .bits_in (b_in),
      .bits_out(bits[k]),
      .len_i   (len_r),
      .hit     (hit[k])
    );
  end

  // each slot's hit comes from exactly the cell at its length
  always_comb begin
    hit_any = '0;
    for (int k = 0; k < MAX_SIG_LEN; k++) begin
      hit_any = hit_any | hit[k];
    end
  end

  always_comb begin
    sel     = '0;
    sel_oh  = '0;
    sel_len = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (pend_r[s]) begin
        sel     = SEL_W'(s);
        sel_oh  = '0;
        sel_oh[s] = 1'b1;
        sel_len = len_r[s];
      end
    end
    diff    = DIF_W'(pos_r) + DIF_W'(1) - DIF_W'(sel_len);
    is_last = ((pend_r & ~sel_oh) == '0) ||
              (ecnt_r == RES_CNT_W_L'(mss_pkg::MAX_RESULTS - 1));
  end

  assign base = in_ch.start_of_file ? '0 : off_r;
  assign sat  = &base;

  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    rep_nxt   = rep_r;
    fill_nxt  = fill_r;
    off_nxt   = off_r;
    pos_nxt   = pos_r;
    en_nxt    = en_r;
    pend_nxt  = pend_r;
    ecnt_nxt  = ecnt_r;
    len_nxt   = len_r;
    ovld_nxt  = ovld_r;
    oslot_nxt = oslot_r;
    ooff_nxt  = ooff_r;
    olast_nxt = olast_r;

    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !in_ch.ready) begin
          state_nxt = S_REPLAY;
          rep_nxt   = '0;
        end else if (in_acc) begin
          case (in_ch.mode)
            mss_pkg::MODE_SIG_BYTE: begin
              dirty_nxt = 1'b1;
            end
            mss_pkg::MODE_SIG_LEN: begin
              dirty_nxt = 1'b1;
              for (int s = 0; s < NUM_SLOTS; s++) begin
                if (32'(in_ch.slot) == s) begin
                  len_nxt[s] = (32'(in_ch.value) > MAX_SIG_LEN) ?
                               LEN_W'(MAX_SIG_LEN) : LEN_W'(in_ch.value);
                end
              end
            end
            mss_pkg::MODE_SCAN: begin
              fill_nxt  = in_ch.start_of_file ? LEN_W'(1) :
                          (fill_r == LEN_W'(MAX_SIG_LEN)) ? fill_r :
                          fill_r + LEN_W'(1);
              pos_nxt   = base;
              en_nxt    = !sat;
              off_nxt   = sat ? base : base + OFFSET_BITS'(1);
              state_nxt = S_HITS;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPLAY: begin
        rep_nxt = rep_r + REP_W'(1);
        if (rep_r == REP_W'(MAX_SIG_LEN - 1)) begin
          dirty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_HITS: begin
        pend_nxt  = en_r ? hit_any : '0;
        ecnt_nxt  = '0;
        state_nxt = (en_r && hit_any != '0) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          oslot_nxt = mss_pkg::SLOT_W'(sel);
          ooff_nxt  = mss_pkg::OUT_OFF_W'(diff);
          olast_nxt = is_last;
          pend_nxt  = pend_r & ~sel_oh;
          ecnt_nxt  = ecnt_r + RES_CNT_W_L'(1);
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dirty_r <= 1'b0;
      fill_r  <= '0;
      off_r   <= '0;
      ovld_r  <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        len_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      fill_r  <= fill_nxt;
      off_r   <= off_nxt;
      ovld_r  <= ovld_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_r   <= rep_nxt;
    pos_r   <= pos_nxt;
    en_r    <= en_nxt;
    pend_r  <= pend_nxt;
    ecnt_r  <= ecnt_nxt;
    oslot_r <= oslot_nxt;
    ooff_r  <= ooff_nxt;
    olast_r <= olast_nxt;
  end

endmodule

[rtl/mss_checker.sv]
// Port-level assertions for the multi-signature byte scanner, bound to the top level.
module mss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [mss_pkg::MODE_W-1:0]     in_mode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_last
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // a load transaction never produces a result right behind it
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != mss_pkg::MODE_SCAN |=> !$rose(out_valid))
    else $error("result appeared after a load transaction");

  // a scanned byte keeps the block busy while its hits are collected
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == mss_pkg::MODE_SCAN |=> !in_ready)
    else $error("input taken while hits were being collected");

  // more results of the same byte follow, so no new input is taken
  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a result burst");

endmodule

bind multi_signature_byte_scanner mss_checker u_mss_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_mode  (in_ch.mode),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_last (out_ch.last)
);

[tb/sv/tb.sv]
// Self-checking testbench for multi_signature_byte_scanner: queued stimulus, predictor, checker.
module tb;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_SIG_LEN = 64;
  localparam int OFFSET_BITS = 16;
  localparam int FILE_ITEMS  = 300;   // random part of the run, load and scan items
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block up
  localparam int DRAIN_CYCLES = 20;   // quiet time after the last expected match is taken

  // the fourth code on the mode field is not decoded by the block
  localparam logic [mss_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [mss_pkg::MODE_W-1:0]  mode;
    logic [mss_pkg::SLOT_W-1:0]  slot;
    logic [mss_pkg::INDEX_W-1:0] byte_index;
    logic [mss_pkg::BYTE_W-1:0]  value;
    logic                        start_of_file;
    bit                          no_gap;      // sender offers the next item right away
  } scan_txn_t;

  typedef struct {
    logic [mss_pkg::SLOT_W-1:0]    match_slot;
    logic [mss_pkg::OUT_OFF_W-1:0] start_offset;
    logic                          last;
  } match_t;

  logic clk;
  logic rst_n;

  mss_in_if  in_ch();
  mss_out_if out_ch();

  multi_signature_byte_scanner #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_SIG_LEN (MAX_SIG_LEN),
    .OFFSET_BITS (OFFSET_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the signature memory, the lengths, the
  // history window (entry 0 is the newest byte) and the next file offset.
  // ---------------------------------------------------------------------------
  logic [mss_pkg::BYTE_W-1:0] sig_bytes [NUM_SLOTS][MAX_SIG_LEN];
  int                         sig_len   [NUM_SLOTS];
  logic [mss_pkg::BYTE_W-1:0] history   [MAX_SIG_LEN];
  logic [OFFSET_BITS-1:0]     next_offset;
  match_t                     expected_matches[$];

  int n_loads, n_scans, n_ignored, n_saturated;
  int n_results, max_per_byte, run_len;
  int errors = 0;

  task automatic scanner_model_reset();
    foreach (sig_len[s]) sig_len[s] = 0;
    foreach (history[i]) history[i] = '0;
    next_offset = '0;
  endtask

  // Apply one accepted transaction and queue the matches it ends.
  task automatic scanner_model_step(input scan_txn_t t);
    int     pos;
    int     len;
    int     cnt;
    int     idx;
    bit     hits [NUM_SLOTS];
    match_t m;
    case (t.mode)
      mss_pkg::MODE_SIG_BYTE: begin
        sig_bytes[t.slot][t.byte_index] = t.value;
        n_loads++;
      end
      mss_pkg::MODE_SIG_LEN: begin
        // lengths past the window clamp to the full window
        sig_len[t.slot] = (t.value > MAX_SIG_LEN) ? MAX_SIG_LEN : int'(t.value);
        n_loads++;
      end
      mss_pkg::MODE_SCAN: begin
        n_scans++;
        if (t.start_of_file) begin
          foreach (history[i]) history[i] = '0;
          next_offset = '0;
        end
        for (int i = MAX_SIG_LEN - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = t.value;
        // a saturated offset still shifts the byte in but reports nothing
        if (next_offset == '1) begin
          n_saturated++;
        end else begin
          pos = int'(next_offset);
          next_offset = next_offset + 1'b1;
          cnt = 0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            len = sig_len[s];
            hits[s] = 1'b0;
            // a signature longer than the bytes seen since file start cannot end here
            if (len != 0 && len <= pos + 1 && cnt < mss_pkg::MAX_RESULTS) begin
              hits[s] = 1'b1;
              for (int k = 0; k < len; k++)
                if (sig_bytes[s][k] != history[len-1-k]) hits[s] = 1'b0;
              if (hits[s]) cnt++;
            end
          end
          idx = 0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (hits[s]) begin
              idx++;
              m.match_slot   = mss_pkg::SLOT_W'(s);
              m.start_offset = mss_pkg::OUT_OFF_W'(pos + 1 - sig_len[s]);
              m.last         = (idx == cnt);
              expected_matches.push_back(m);
            end
          end
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops pending transactions, pauses for a random gap after each one
  // unless the item asks for back-to-back, predicts on acceptance.
  // ---------------------------------------------------------------------------
  scan_txn_t pending_items[$];
  scan_txn_t cur_txn;
  bit        txn_held;
  int        gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.mode          <= mss_pkg::MODE_SIG_BYTE;
      in_ch.slot          <= '0;
      in_ch.byte_index    <= '0;
      in_ch.value         <= '0;
      in_ch.start_of_file <= 1'b0;
      txn_held = 1'b0;
      gap_left = 0;
      scanner_model_reset();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scanner_model_step(cur_txn);
        txn_held = 1'b0;
        gap_left = cur_txn.no_gap ? 0 : $urandom_range(0, 3);
      end
      if (!txn_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_txn  = pending_items.pop_front();
          txn_held = 1'b1;
          in_ch.mode          <= cur_txn.mode;
          in_ch.slot          <= cur_txn.slot;
          in_ch.byte_index    <= cur_txn.byte_index;
          in_ch.value         <= cur_txn.value;
          in_ch.start_of_file <= cur_txn.start_of_file;
        end
      end
      in_ch.valid <= txn_held;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each match result against the oldest prediction. Ready
  // drops for a random stall after each transaction, with stall-free stretches,
  // and once for a long hold-off while the sender keeps offering bytes.
  // ---------------------------------------------------------------------------
  bit     squeeze_req = 1'b0;
  bit     squeeze_done = 1'b0;
  int     stall_left, steady_left, hold_left;
  match_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left  = 0;
      steady_left = 0;
      hold_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected match: expected none, got slot %0d offset %0d last %0b",
                   $time, out_ch.match_slot, out_ch.start_offset, out_ch.last);
          errors++;
        end else begin
          want = expected_matches.pop_front();
          if (out_ch.match_slot !== want.match_slot) begin
            $display("%0t: match_slot mismatch: expected %0d, got %0d",
                     $time, want.match_slot, out_ch.match_slot);
            errors++;
          end
          if (out_ch.start_offset !== want.start_offset) begin
            $display("%0t: start_offset mismatch: expected %0d, got %0d",
                     $time, want.start_offset, out_ch.start_offset);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want.last, out_ch.last);
            errors++;
          end
        end
        n_results++;
        run_len++;
        if (out_ch.last) begin
          if (run_len > max_per_byte) max_per_byte = run_len;
          run_len = 0;
        end
        if (steady_left > 0) begin
          steady_left--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) steady_left = 24;
        end
      end
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus planning. The plan keeps its own view of the signatures so that
  // scanned sequences can be built to hit them; every length is only ever set
  // after all of its bytes were written.
  // ---------------------------------------------------------------------------
  logic [mss_pkg::BYTE_W-1:0] plan_sig [NUM_SLOTS][MAX_SIG_LEN];
  int                         plan_len [NUM_SLOTS];
  int                         plan_cnt;
  int                         plan_tight_left = 0;

  task automatic queue_txn(input logic [mss_pkg::MODE_W-1:0] mode, input int slot,
                           input int idx, input int value, input bit sof);
    scan_txn_t t;
    t.mode          = mode;
    t.slot          = mss_pkg::SLOT_W'(slot);
    t.byte_index    = mss_pkg::INDEX_W'(idx);
    t.value         = mss_pkg::BYTE_W'(value);
    t.start_of_file = sof;
    // occasional back-to-back stretches on the input side
    if (plan_tight_left > 0) plan_tight_left--;
    else if ($urandom_range(0, 39) == 0) plan_tight_left = 20;
    t.no_gap = plan_tight_left > 0;
    if (mode == mss_pkg::MODE_SIG_BYTE) plan_sig[slot][idx] = mss_pkg::BYTE_W'(value);
    if (mode == mss_pkg::MODE_SIG_LEN)
      plan_len[slot] = (value > MAX_SIG_LEN) ? MAX_SIG_LEN : value;
    if (mode != MODE_UNUSED) plan_cnt++;
    pending_items.push_back(t);
  endtask

  // small alphabet most of the time so that scans collide with signatures
  function automatic int pick_byte();
    if ($urandom_range(0, 3) != 0) return 'h41 + $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  task automatic load_signature(input int slot, input int len_value);
    int n;
    n = (len_value > MAX_SIG_LEN) ? MAX_SIG_LEN : len_value;
    for (int k = 0; k < n; k++)
      queue_txn(mss_pkg::MODE_SIG_BYTE, slot, k, pick_byte(), $urandom_range(0, 1));
    queue_txn(mss_pkg::MODE_SIG_LEN, slot, $urandom_range(0, 63), len_value,
              $urandom_range(0, 1));
  endtask

  task automatic scan_signature(input int slot, input bit sof);
    for (int k = 0; k < plan_len[slot]; k++)
      queue_txn(mss_pkg::MODE_SCAN, $urandom_range(0, 7), $urandom_range(0, 63),
                plan_sig[slot][k], sof && k == 0);
  endtask

  initial begin
    int enabled[$];
    int r;
    clk   = 1'b0;
    rst_n = 1'b0;
    foreach (plan_len[s]) plan_len[s] = 0;

    // directed part
    queue_txn(mss_pkg::MODE_SCAN, 0, 0, 'h00, 1'b1);          // nothing enabled yet
    queue_txn(MODE_UNUSED, 7, 63, 'hFF, 1'b1);                // undecoded mode, dropped
    for (int s = 0; s < NUM_SLOTS; s++) queue_txn(mss_pkg::MODE_SIG_BYTE, s, 0, 'hFF, 1'b0);
    queue_txn(mss_pkg::MODE_SIG_BYTE, 0, 1, 'hFF, 1'b0);
    queue_txn(mss_pkg::MODE_SIG_LEN, 0, 0, 2, 1'b0);
    // file-start flag on a load must not disturb the scan state
    for (int s = 1; s < NUM_SLOTS; s++)
      queue_txn(mss_pkg::MODE_SIG_LEN, s, 0, 1, s == NUM_SLOTS - 1);
    queue_txn(mss_pkg::MODE_SCAN, 0, 0, 'hFF, 1'b1);  // two-byte slot too long for the file yet
    queue_txn(mss_pkg::MODE_SCAN, 0, 0, 'hFF, 1'b0);  // every slot hits: eight results
    queue_txn(mss_pkg::MODE_SCAN, 0, 0, 'h00, 1'b0);
    queue_txn(mss_pkg::MODE_SIG_LEN, 3, 0, 0, 1'b0);  // disable one slot
    queue_txn(mss_pkg::MODE_SCAN, 0, 0, 'hFF, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || txn_held) @(posedge clk);

    // random part: a full-window signature with a clamped length first
    plan_cnt = 0;
    load_signature(5, $urandom_range(MAX_SIG_LEN, 255));
    scan_signature(5, 1'b0);
    while (plan_cnt < FILE_ITEMS) begin
      r = $urandom_range(0, 99);
      enabled.delete();
      for (int i = 0; i < NUM_SLOTS; i++) if (plan_len[i] > 0) enabled.push_back(i);
      if (r < 12 || enabled.size() == 0) begin
        load_signature($urandom_range(0, 7),
                       ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6) :
                                                     $urandom_range(0, 70));
      end else if (r < 55) begin
        repeat ($urandom_range(0, 3))
          queue_txn(mss_pkg::MODE_SCAN, $urandom_range(0, 7), $urandom_range(0, 63),
                    pick_byte(), 1'b0);
        scan_signature(enabled[$urandom_range(0, enabled.size() - 1)],
                       $urandom_range(0, 9) == 0);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6))
          queue_txn(mss_pkg::MODE_SCAN, $urandom_range(0, 7), $urandom_range(0, 63),
                    pick_byte(), $urandom_range(0, 19) == 0);
      end else if (r < 90) begin
        queue_txn(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 1));
      end else if (r < 95) begin
        // stray byte write, may land inside an enabled signature
        queue_txn(mss_pkg::MODE_SIG_BYTE, $urandom_range(0, 7), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 1));
      end else begin
        queue_txn(mss_pkg::MODE_SIG_LEN, $urandom_range(0, 7), $urandom_range(0, 63), 0,
                  $urandom_range(0, 1));
      end
    end

    // halfway through, the receiver holds off and the input backs up
    while (pending_items.size() > FILE_ITEMS / 2) @(posedge clk);
    squeeze_req = 1'b1;
    while (pending_items.size() != 0 || txn_held) @(posedge clk);

    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d loads, %0d scanned bytes (%0d at a saturated offset), %0d ignored",
             n_loads, n_scans, n_saturated, n_ignored);
    $display("%0d match results checked, up to %0d from a single byte, %0d errors",
             n_results, max_per_byte, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/mss_pkg.sv
rtl/mss_if.sv
rtl/mss_cell.sv
rtl/multi_signature_byte_scanner.sv
rtl/mss_checker.sv
tb/sv/tb.sv
